// ===== rtl/nps_pkg.sv =====
package nps_pkg;

  // Fixed widths of the port fields.
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 24;
  localparam int INDEX_W  = 10;
  localparam int DIST_W   = 50;

  // Squared distances saturate at the largest value the result word can hold.
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Defaults for the top-level parameters.
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 24;

  // Operation codes of an input word.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // Status codes of a result word.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_WAIT = 3'b100
  } state_t;

endpackage

// ===== rtl/nearest_point_search_3d.sv =====
// Channel  | Handshake        | Words
// ---------+------------------+---------------------------------------------------
// command  | start, busy      | operation, pos_x, pos_y, pos_z
// result   | done (strobe)    | status, match_index, min_distance, near_x/y/z
//
// A command word is taken at a clock edge with start high and busy low.
// Clear, append, an unused code and a query on an empty store give their result
// word in the next cycle and never raise busy. A query with n stored points
// reads one point per cycle from the coordinate memory into the distance pipeline
// (read, magnitude, square, sum, saturate); the single memory read port sets that
// rate. Busy is high for the whole scan.
// Each result word is shown on done for one cycle only; the receiver cannot stall.
// Synchronous reset empties the store and idles the sequencer.
module nearest_point_search_3d
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            operation,
  input  logic signed [FIELD_W-1:0]  pos_x,
  input  logic signed [FIELD_W-1:0]  pos_y,
  input  logic signed [FIELD_W-1:0]  pos_z,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [INDEX_W-1:0]         match_index,
  output logic [DIST_W-1:0]          min_distance,
  output logic signed [FIELD_W-1:0]  near_x,
  output logic signed [FIELD_W-1:0]  near_y,
  output logic signed [FIELD_W-1:0]  near_z
);

  localparam int CB    = COORD_BITS;
  localparam int IDXW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW  = $clog2(MAX_POINTS + 1);
  localparam int MAGW  = CB + 1;
  localparam int SQW   = 2 * MAGW;
  localparam int SUMW  = (SQW + 2 > DIST_W + 1) ? SQW + 2 : DIST_W + 1;

  // Coordinate memories.
  logic [CB-1:0] store_x [MAX_POINTS];
  logic [CB-1:0] store_y [MAX_POINTS];
  logic [CB-1:0] store_z [MAX_POINTS];

  state_t          state;
  logic [CNTW-1:0] count;
  logic [IDXW-1:0] rd_addr;
  logic [CB-1:0]   q_x, q_y, q_z;

  logic [CB-1:0]   in_x, in_y, in_z;
  logic            accept, full, empty, scan_last;

  // Pipeline registers of the distance unit.
  logic            p1_v, p2_v, p3_v, p4_v, p5_v;
  logic            p1_last, p2_last, p3_last, p4_last, p5_last;
  logic [IDXW-1:0] p1_idx, p2_idx, p3_idx, p4_idx, p5_idx;
  logic [CB-1:0]   p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z;
  logic [CB-1:0]   p4_x, p4_y, p4_z, p5_x, p5_y, p5_z;
  logic [MAGW-1:0] mag_x, mag_y, mag_z;
  logic [SQW-1:0]  sq_x, sq_y, sq_z;
  logic [SUMW-1:0] sum;
  logic [DIST_W-1:0] cand_dist;

  // Running best match.
  logic [DIST_W-1:0] best_dist;
  logic [IDXW-1:0]   best_idx;
  logic [CB-1:0]     best_x, best_y, best_z;

  // Candidate picked in the compare stage.
  logic              take;
  logic [DIST_W-1:0] win_dist;
  logic [IDXW-1:0]   win_idx;
  logic [CB-1:0]     win_x, win_y, win_z;
  logic [INDEX_W-1:0] win_index_out;
  logic [FIELD_W-1:0] win_x_out, win_y_out, win_z_out;

  logic signed [MAGW-1:0] dx, dy, dz;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign full      = (count == CNTW'(MAX_POINTS));
  assign empty     = (count == '0);
  assign scan_last = ((CNTW'(rd_addr) + CNTW'(1)) == count);

  // Input coordinates are taken at the configured width.
  generate
    if (CB <= FIELD_W) begin : g_in_narrow
      assign in_x = pos_x[CB-1:0];
      assign in_y = pos_y[CB-1:0];
      assign in_z = pos_z[CB-1:0];
    end else begin : g_in_wide
      assign in_x = {{(CB-FIELD_W){1'b0}}, pos_x};
      assign in_y = {{(CB-FIELD_W){1'b0}}, pos_y};
      assign in_z = {{(CB-FIELD_W){1'b0}}, pos_z};
    end
  endgenerate

  // Sequencer, point counter and scan address.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_addr <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (op_t'(operation))
              OP_CLEAR:  count <= '0;
              OP_APPEND: begin
                if (!full) begin
                  count <= count + CNTW'(1);
                end
              end
              OP_QUERY: begin
                if (!empty) begin
                  rd_addr <= '0;
                  state   <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_WAIT;
          end else begin
            rd_addr <= rd_addr + IDXW'(1);
          end
        end
        S_WAIT: begin
          if (p5_v && p5_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Query point is held for the whole scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_x <= in_x;
      q_y <= in_y;
      q_z <= in_z;
    end
  end

  // Memory write on append and registered read during the scan.
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_APPEND) && !full) begin
      store_x[count[IDXW-1:0]] <= in_x;
      store_y[count[IDXW-1:0]] <= in_y;
      store_z[count[IDXW-1:0]] <= in_z;
    end
    p1_x <= store_x[rd_addr];
    p1_y <= store_y[rd_addr];
    p1_z <= store_z[rd_addr];
  end

  // Signed differences to the query point.
  assign dx = $signed({q_x[CB-1], q_x}) - $signed({p1_x[CB-1], p1_x});
  assign dy = $signed({q_y[CB-1], q_y}) - $signed({p1_y[CB-1], p1_y});
  assign dz = $signed({q_z[CB-1], q_z}) - $signed({p1_z[CB-1], p1_z});

  // Valid flags of the distance pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p5_v <= 1'b0;
    end else begin
      p1_v <= (state == S_SCAN);
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
      p5_v <= p4_v;
    end
  end

  // Distance datapath: magnitude, square, sum, saturate.
  always_ff @(posedge clk) begin
    p1_last <= (state == S_SCAN) && scan_last;
    p1_idx  <= rd_addr;

    mag_x   <= dx[MAGW-1] ? MAGW'(-dx) : MAGW'(dx);
    mag_y   <= dy[MAGW-1] ? MAGW'(-dy) : MAGW'(dy);
    mag_z   <= dz[MAGW-1] ? MAGW'(-dz) : MAGW'(dz);
    p2_last <= p1_last;
    p2_idx  <= p1_idx;
    p2_x    <= p1_x;
    p2_y    <= p1_y;
    p2_z    <= p1_z;

    sq_x    <= SQW'(mag_x) * SQW'(mag_x);
    sq_y    <= SQW'(mag_y) * SQW'(mag_y);
    sq_z    <= SQW'(mag_z) * SQW'(mag_z);
    p3_last <= p2_last;
    p3_idx  <= p2_idx;
    p3_x    <= p2_x;
    p3_y    <= p2_y;
    p3_z    <= p2_z;

    sum     <= SUMW'(sq_x) + SUMW'(sq_y) + SUMW'(sq_z);
    p4_last <= p3_last;
    p4_idx  <= p3_idx;
    p4_x    <= p3_x;
    p4_y    <= p3_y;
    p4_z    <= p3_z;

    cand_dist <= (sum > SUMW'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    p5_last <= p4_last;
    p5_idx  <= p4_idx;
    p5_x    <= p4_x;
    p5_y    <= p4_y;
    p5_z    <= p4_z;
  end

  // The first point always loads; later ones must be strictly closer.
  always_comb begin
    take     = (p5_idx == '0) || (cand_dist < best_dist);
    win_dist = take ? cand_dist : best_dist;
    win_idx  = take ? p5_idx : best_idx;
    win_x    = take ? p5_x  : best_x;
    win_y    = take ? p5_y  : best_y;
    win_z    = take ? p5_z  : best_z;
  end

  always_ff @(posedge clk) begin
    if (p5_v) begin
      best_dist <= win_dist;
      best_idx  <= win_idx;
      best_x    <= win_x;
      best_y    <= win_y;
      best_z    <= win_z;
    end
  end

  // Fit index and stored coordinates to the result word.
  generate
    if (IDXW >= INDEX_W) begin : g_idx_wide
      assign win_index_out = win_idx[INDEX_W-1:0];
    end else begin : g_idx_narrow
      assign win_index_out = {{(INDEX_W-IDXW){1'b0}}, win_idx};
    end
    if (CB >= FIELD_W) begin : g_out_wide
      assign win_x_out = win_x[FIELD_W-1:0];
      assign win_y_out = win_y[FIELD_W-1:0];
      assign win_z_out = win_z[FIELD_W-1:0];
    end else begin : g_out_narrow
      assign win_x_out = {{(FIELD_W-CB){1'b0}}, win_x};
      assign win_y_out = {{(FIELD_W-CB){1'b0}}, win_y};
      assign win_z_out = {{(FIELD_W-CB){1'b0}}, win_z};
    end
  endgenerate

  // Result word register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && !((operation == OP_QUERY) && !empty)) || (p5_v && p5_last);
    end
  end

  always_ff @(posedge clk) begin
    if (p5_v && p5_last) begin
      status       <= ST_OK;
      match_index  <= win_index_out;
      min_distance <= win_dist;
      near_x       <= win_x_out;
      near_y       <= win_y_out;
      near_z       <= win_z_out;
    end else if (accept) begin
      match_index  <= '0;
      min_distance <= '0;
      near_x       <= '0;
      near_y       <= '0;
      near_z       <= '0;
      if ((operation == OP_QUERY) && empty) begin
        status <= ST_EMPTY;
      end else if ((operation == OP_APPEND) && full) begin
        status <= ST_FULL;
      end else begin
        status <= ST_OK;
      end
    end
  end

  // No result word leaves while the scan is still issuing reads.
  a_no_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !done)
    else $error("result strobe during scan");

  // The store does not change while a query is in progress.
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("point count changed during a query");

  // The last point reaches the compare stage only after all reads were issued.
  a_last_in_wait: assert property (@(posedge clk) disable iff (rst)
    (p5_v && p5_last) |-> (state == S_WAIT))
    else $error("scan end out of step with sequencer");

endmodule
